### sv/u8dec_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 decoder package
// Shared types, codes, defaults and the Windows-1252 table for bytes 0x80 to 0x9F.
// ----------------------------------------------------------------------------
`default_nettype none

package u8dec_pkg;

    localparam int LINE_BITS_DEF   = 24;
    localparam int COLUMN_BITS_DEF = 16;

    localparam logic [20:0] BOM_SCALAR = 21'h00FEFF;
    localparam logic [20:0] NEWLINE_CP = 21'd10;

    typedef enum logic [1:0] {
        KIND_CP  = 2'd0,
        KIND_EOF = 2'd1,
        KIND_ERR = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_TRUNCATED = 3'd1,
        ERR_BAD_CONT  = 3'd2,
        ERR_BAD_SCAL  = 3'd3,
        ERR_BAD_LEAD  = 3'd4
    } t_err;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_source;
    } t_in;

    typedef struct packed {
        t_kind       kind;
        logic [20:0] char_value;
        logic [23:0] line_number;
        logic [15:0] column_number;
        t_err        error_code;
        logic        last_of_run;
    } t_out;

    function automatic logic [20:0] cp1252_high(input logic [4:0] idx);
        logic [20:0] cp;
        unique case (idx)
            5'd0:  cp = 21'h20AC;
            5'd1:  cp = 21'h0081;
            5'd2:  cp = 21'h201A;
            5'd3:  cp = 21'h0192;
            5'd4:  cp = 21'h201E;
            5'd5:  cp = 21'h2026;
            5'd6:  cp = 21'h2020;
            5'd7:  cp = 21'h2021;
            5'd8:  cp = 21'h02C6;
            5'd9:  cp = 21'h2030;
            5'd10: cp = 21'h0160;
            5'd11: cp = 21'h2039;
            5'd12: cp = 21'h0152;
            5'd13: cp = 21'h008D;
            5'd14: cp = 21'h017D;
            5'd15: cp = 21'h008F;
            5'd16: cp = 21'h0090;
            5'd17: cp = 21'h2018;
            5'd18: cp = 21'h2019;
            5'd19: cp = 21'h201C;
            5'd20: cp = 21'h201D;
            5'd21: cp = 21'h2022;
            5'd22: cp = 21'h2013;
            5'd23: cp = 21'h2014;
            5'd24: cp = 21'h02DC;
            5'd25: cp = 21'h2122;
            5'd26: cp = 21'h0161;
            5'd27: cp = 21'h203A;
            5'd28: cp = 21'h0153;
            5'd29: cp = 21'h009D;
            5'd30: cp = 21'h017E;
            default: cp = 21'h0178;
        endcase
        return cp;
    endfunction

endpackage

`default_nettype wire

### sv/utf8_decoder_with_position.sv
// ----------------------------------------------------------------------------
// UTF-8 decoder with source position
// Decodes source bytes into code points tagged with line and column, and reports
// malformed input as errors; a clean end adds a missing newline and an end marker.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  in      | input     | i_in_valid / o_in_stall   | i_in_data  (u8dec_pkg::t_in)
//  out     | output    | o_out_valid / i_out_stall | o_out_data (u8dec_pkg::t_out)
//
//  One byte is taken per cycle while the input is not stalled; the decoder
//  state updates in the same cycle. A byte yields up to three results, held
//  in a three-entry result register that drains one transfer per cycle while
//  the output is not stalled. The input stalls only while more than one result
//  waits or a single waiting result is itself stalled. Reset is synchronous.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_decoder_with_position #(
    parameter int LINE_BITS   = u8dec_pkg::LINE_BITS_DEF,
    parameter int COLUMN_BITS = u8dec_pkg::COLUMN_BITS_DEF
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_stall,
    input  wire u8dec_pkg::t_in i_in_data,
    output logic             o_out_valid,
    input  wire              i_out_stall,
    output u8dec_pkg::t_out  o_out_data
);

    localparam logic [LINE_BITS-1:0]   LINE_ONE = LINE_BITS'(1);
    localparam logic [COLUMN_BITS-1:0] COL_ONE  = COLUMN_BITS'(1);

    function automatic logic [LINE_BITS-1:0] sat_line(input logic [LINE_BITS-1:0] v);
        return (v == '1) ? v : v + LINE_ONE;
    endfunction

    function automatic logic [COLUMN_BITS-1:0] sat_col(input logic [COLUMN_BITS-1:0] v);
        return (v == '1) ? v : v + COL_ONE;
    endfunction

    function automatic u8dec_pkg::t_out make_res(
        input u8dec_pkg::t_kind        kind,
        input logic [20:0]             cp,
        input logic [LINE_BITS-1:0]    line,
        input logic [COLUMN_BITS-1:0]  col,
        input u8dec_pkg::t_err         err
    );
        u8dec_pkg::t_out r;
        logic [31:0]     lw;
        logic [31:0]     cw;
        lw              = 32'(line);
        cw              = 32'(col);
        r.kind          = kind;
        r.char_value    = cp;
        r.line_number   = lw[23:0];
        r.column_number = cw[15:0];
        r.error_code    = err;
        r.last_of_run   = 1'b0;
        return r;
    endfunction

    // Decoder state
    logic [20:0]            r_partial,  n_partial;
    logic [1:0]             r_rem,      n_rem;
    logic [2:0]             r_seq_len,  n_seq_len;
    logic                   r_inv,      n_inv;
    logic                   r_at_start, n_at_start;
    logic                   r_anything, n_anything;
    logic                   r_last_nl,  n_last_nl;
    logic [LINE_BITS-1:0]   r_seq_line, n_seq_line;
    logic [COLUMN_BITS-1:0] r_seq_col,  n_seq_col;
    logic [LINE_BITS-1:0]   r_line,     n_line;
    logic [COLUMN_BITS-1:0] r_col,      n_col;
    logic                   r_dropping, n_dropping;

    // Result register
    u8dec_pkg::t_out        r_slot [0:2];
    u8dec_pkg::t_out        n_slot [0:2];
    logic [1:0]             r_cnt,      n_cnt;

    logic                   in_acc;
    logic                   out_take;
    logic [7:0]             b;
    logic [5:0]             c;
    logic                   a_v;
    logic [20:0]            a_cp;
    logic [LINE_BITS-1:0]   a_line;
    logic [COLUMN_BITS-1:0] a_col;
    logic                   e_v;
    u8dec_pkg::t_err        e_code;
    logic [LINE_BITS-1:0]   e_line;
    logic [COLUMN_BITS-1:0] e_col;
    logic                   nl_v;
    logic                   f_v;
    logic [LINE_BITS-1:0]   nl_line;
    logic [COLUMN_BITS-1:0] nl_col;
    logic                   src_done;

    assign out_take    = o_out_valid && !i_out_stall;
    assign o_out_valid = (r_cnt != 2'd0);
    assign o_out_data  = r_slot[0];
    assign o_in_stall  = !((r_cnt == 2'd0) || ((r_cnt == 2'd1) && out_take));
    assign in_acc      = i_in_valid && !o_in_stall;
    assign b           = i_in_data.data_byte;
    assign c           = i_in_data.data_byte[5:0];

    always_comb begin
        n_partial  = r_partial;
        n_rem      = r_rem;
        n_seq_len  = r_seq_len;
        n_inv      = r_inv;
        n_at_start = r_at_start;
        n_anything = r_anything;
        n_last_nl  = r_last_nl;
        n_seq_line = r_seq_line;
        n_seq_col  = r_seq_col;
        n_line     = r_line;
        n_col      = r_col;
        n_dropping = r_dropping;
        a_v        = 1'b0;
        a_cp       = '0;
        a_line     = r_line;
        a_col      = r_col;
        e_v        = 1'b0;
        e_code     = u8dec_pkg::ERR_NONE;
        e_line     = r_line;
        e_col      = r_col;
        nl_v       = 1'b0;
        f_v        = 1'b0;
        nl_line    = r_line;
        nl_col     = r_col;
        src_done   = 1'b0;

        if (r_dropping) begin
            src_done = i_in_data.end_of_source;
        end else begin
            if (i_in_data.has_byte) begin
                if (r_rem == 2'd0) begin
                    n_seq_line = r_line;
                    n_seq_col  = r_col;
                    if (b < 8'h80) begin
                        a_v  = 1'b1;
                        a_cp = 21'(b);
                    end else if (b <= 8'hBF) begin
                        a_v  = 1'b1;
                        a_cp = (b <= 8'h9F) ? u8dec_pkg::cp1252_high(b[4:0]) : 21'(b);
                    end else if (b >= 8'hC2 && b <= 8'hDF) begin
                        n_partial = 21'(b[4:0]);
                        n_rem     = 2'd1;
                        n_seq_len = 3'd2;
                        n_inv     = 1'b0;
                    end else if (b >= 8'hE0 && b <= 8'hEF) begin
                        n_partial = 21'(b[3:0]);
                        n_rem     = 2'd2;
                        n_seq_len = 3'd3;
                        n_inv     = 1'b0;
                    end else if (b >= 8'hF0 && b <= 8'hF4) begin
                        n_partial = 21'(b[2:0]);
                        n_rem     = 2'd3;
                        n_seq_len = 3'd4;
                        n_inv     = 1'b0;
                    end else begin
                        e_v    = 1'b1;
                        e_code = u8dec_pkg::ERR_BAD_LEAD;
                    end
                end else if (b[7:6] != 2'b10) begin
                    e_v    = 1'b1;
                    e_code = u8dec_pkg::ERR_BAD_CONT;
                    e_line = r_seq_line;
                    e_col  = r_seq_col;
                end else begin
                    if (r_seq_len - 3'(r_rem) == 3'd1) begin
                        if (r_seq_len == 3'd3 &&
                            ((r_partial == 21'd0 && c < 6'h20) ||
                             (r_partial == 21'hD && c >= 6'h20))) begin
                            n_inv = 1'b1;
                        end
                        if (r_seq_len == 3'd4 &&
                            ((r_partial == 21'd0 && c < 6'h10) ||
                             (r_partial == 21'd4 && c >= 6'h10))) begin
                            n_inv = 1'b1;
                        end
                    end
                    n_partial = {r_partial[14:0], c};
                    n_rem     = r_rem - 2'd1;
                    if (n_rem == 2'd0) begin
                        if (n_inv) begin
                            e_v    = 1'b1;
                            e_code = u8dec_pkg::ERR_BAD_SCAL;
                            e_line = r_seq_line;
                            e_col  = r_seq_col;
                        end else if (n_partial == u8dec_pkg::BOM_SCALAR && r_at_start) begin
                            n_at_start = 1'b0;
                        end else begin
                            a_v    = 1'b1;
                            a_cp   = n_partial;
                            a_line = r_seq_line;
                            a_col  = r_seq_col;
                        end
                        n_seq_len = 3'd0;
                        n_inv     = 1'b0;
                    end
                end
            end

            if (a_v) begin
                n_anything = 1'b1;
                n_last_nl  = (a_cp == u8dec_pkg::NEWLINE_CP);
                n_at_start = 1'b0;
                if (a_cp == u8dec_pkg::NEWLINE_CP) begin
                    n_line = sat_line(r_line);
                    n_col  = COL_ONE;
                end else begin
                    n_col  = sat_col(r_col);
                end
            end

            if (!e_v && i_in_data.end_of_source && n_rem != 2'd0) begin
                e_v    = 1'b1;
                e_code = u8dec_pkg::ERR_TRUNCATED;
                e_line = n_seq_line;
                e_col  = n_seq_col;
            end

            nl_line = n_line;
            nl_col  = n_col;

            if (e_v) begin
                if (i_in_data.end_of_source) begin
                    src_done = 1'b1;
                end else begin
                    n_rem      = 2'd0;
                    n_seq_len  = 3'd0;
                    n_inv      = 1'b0;
                    n_dropping = 1'b1;
                end
            end else if (i_in_data.end_of_source) begin
                nl_v     = n_anything && !n_last_nl;
                f_v      = 1'b1;
                src_done = 1'b1;
                if (nl_v) begin
                    n_line = sat_line(nl_line);
                    n_col  = COL_ONE;
                end
            end
        end

        n_cnt     = 2'd0;
        n_slot[0] = '0;
        n_slot[1] = '0;
        n_slot[2] = '0;
        if (a_v) begin
            n_slot[n_cnt] = make_res(u8dec_pkg::KIND_CP, a_cp, a_line, a_col,
                                     u8dec_pkg::ERR_NONE);
            n_cnt = n_cnt + 2'd1;
        end
        if (e_v) begin
            n_slot[n_cnt] = make_res(u8dec_pkg::KIND_ERR, '0, e_line, e_col, e_code);
            n_cnt = n_cnt + 2'd1;
        end
        if (nl_v) begin
            n_slot[n_cnt] = make_res(u8dec_pkg::KIND_CP, u8dec_pkg::NEWLINE_CP,
                                     nl_line, nl_col, u8dec_pkg::ERR_NONE);
            n_cnt = n_cnt + 2'd1;
        end
        if (f_v) begin
            n_slot[n_cnt] = make_res(u8dec_pkg::KIND_EOF, '0, n_line, n_col,
                                     u8dec_pkg::ERR_NONE);
            n_cnt = n_cnt + 2'd1;
        end
        if (n_cnt != 2'd0) begin
            n_slot[n_cnt - 2'd1].last_of_run = 1'b1;
        end

        if (src_done) begin
            n_partial  = '0;
            n_rem      = 2'd0;
            n_seq_len  = 3'd0;
            n_inv      = 1'b0;
            n_at_start = 1'b1;
            n_anything = 1'b0;
            n_last_nl  = 1'b0;
            n_seq_line = LINE_ONE;
            n_seq_col  = COL_ONE;
            n_line     = LINE_ONE;
            n_col      = COL_ONE;
            n_dropping = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial  <= '0;
            r_rem      <= 2'd0;
            r_seq_len  <= 3'd0;
            r_inv      <= 1'b0;
            r_at_start <= 1'b1;
            r_anything <= 1'b0;
            r_last_nl  <= 1'b0;
            r_seq_line <= LINE_ONE;
            r_seq_col  <= COL_ONE;
            r_line     <= LINE_ONE;
            r_col      <= COL_ONE;
            r_dropping <= 1'b0;
            r_cnt      <= 2'd0;
        end else begin
            if (in_acc) begin
                r_partial  <= n_partial;
                r_rem      <= n_rem;
                r_seq_len  <= n_seq_len;
                r_inv      <= n_inv;
                r_at_start <= n_at_start;
                r_anything <= n_anything;
                r_last_nl  <= n_last_nl;
                r_seq_line <= n_seq_line;
                r_seq_col  <= n_seq_col;
                r_line     <= n_line;
                r_col      <= n_col;
                r_dropping <= n_dropping;
                r_cnt      <= n_cnt;
            end else if (out_take) begin
                r_cnt      <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_slot[0] <= n_slot[0];
            r_slot[1] <= n_slot[1];
            r_slot[2] <= n_slot[2];
        end else if (out_take) begin
            r_slot[0] <= r_slot[1];
            r_slot[1] <= r_slot[2];
        end
    end

`ifndef SYNTHESIS
    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != 2'd0) |-> (r_slot[0].last_of_run == (r_cnt == 2'd1)))
        else $error("last_of_run does not match the pending result count");

    a_drop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dropping |-> (r_rem == 2'd0 && r_seq_len == 3'd0))
        else $error("sequence still open while dropping after an error");

    a_seq_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rem != 2'd0) |-> (3'(r_rem) < r_seq_len))
        else $error("remaining byte count exceeds the sequence length");

    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.kind == u8dec_pkg::KIND_ERR)
            |-> (o_out_data.error_code != u8dec_pkg::ERR_NONE))
        else $error("error result without an error code");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed");
`endif

endmodule

`default_nettype wire
